[sv/egsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egsd_pkg
// shared constants and types of the elias gamma stream decoder
// ----------------------------------------------------------------------------
package egsd_pkg;

  localparam int BYTE_BITS     = 8;
  localparam int BIT_CNT_W     = $clog2(BYTE_BITS + 1);
  localparam int OUT_BITS      = 32;
  localparam int CODE_BITS_DEF = 32;
  localparam int QUEUE_DEPTH   = 2;

  // one byte request as held in the queue
  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 restart;
  } egsd_req_t;

  // one finished result
  typedef struct packed {
    logic [OUT_BITS-1:0]        code;
    logic signed [OUT_BITS-1:0] sval;
    logic                       too_long;
    logic                       last;
  } egsd_res_t;

endpackage

[sv/egsd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egsd_front
// accepts byte requests into a short queue ahead of the bit walker
// ----------------------------------------------------------------------------
module egsd_front import egsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_BITS-1:0] data_byte,
  input  logic                 restart,
  output logic                 q_valid,
  output egsd_req_t            q_req,
  input  logic                 q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  egsd_req_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_stall = (count == CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_req    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{data: data_byte, restart: restart};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/egsd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egsd_back
// walks one bit per cycle unless a full pending slot holds it, builds gamma codes and delivers results
// ----------------------------------------------------------------------------
module egsd_back import egsd_pkg::*; #(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  egsd_req_t q_req,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output egsd_res_t out_res
);

  localparam int RUN_W = $clog2(CODE_BITS + 1);
  localparam int WIDE  = (CODE_BITS > OUT_BITS) ? CODE_BITS : OUT_BITS;

  // walker
  logic [BYTE_BITS-1:0] shreg;
  logic [BIT_CNT_W-1:0] bits_left;
  logic                 have_bit;
  logic                 last_bit;
  logic                 cur_bit;
  logic                 go;
  logic                 load;

  // code state
  logic [CODE_BITS-1:0] partial_code, partial_code_next;
  logic [RUN_W-1:0]     zero_run, zero_run_next;
  logic [RUN_W-1:0]     suffix_left, suffix_left_next;
  logic                 in_suffix, in_suffix_next;
  logic [RUN_W-1:0]     run_inc;
  logic [RUN_W-1:0]     suffix_dec;
  logic [CODE_BITS-1:0] code_shift;

  // result of this bit
  logic                 res;
  logic                 res_err;
  logic [CODE_BITS-1:0] res_code;
  logic [WIDE-1:0]      code_w;
  logic [WIDE-1:0]      half_w;
  logic [WIDE-1:0]      sval_w;

  // pending result and output register
  egsd_res_t pend;
  logic      pend_valid;
  logic      pend_done;
  logic      o_free;
  logic      mv;

  assign have_bit   = (bits_left != '0);
  assign last_bit   = (bits_left == BIT_CNT_W'(1));
  assign cur_bit    = shreg[BYTE_BITS-1];
  assign run_inc    = zero_run + 1'b1;
  assign suffix_dec = suffix_left - 1'b1;
  assign code_shift = {partial_code[CODE_BITS-2:0], cur_bit};

  always_comb begin
    partial_code_next = partial_code;
    zero_run_next     = zero_run;
    suffix_left_next  = suffix_left;
    in_suffix_next    = in_suffix;
    res               = 1'b0;
    res_err           = 1'b0;
    res_code          = '0;
    if (!in_suffix) begin
      if (!cur_bit) begin
        zero_run_next = run_inc;
        if (run_inc >= RUN_W'(CODE_BITS)) begin
          res               = 1'b1;
          res_err           = 1'b1;
          partial_code_next = '0;
          zero_run_next     = '0;
          suffix_left_next  = '0;
        end
      end else if (zero_run == '0) begin
        // single-bit code
        res               = 1'b1;
        res_code          = CODE_BITS'(1);
        partial_code_next = '0;
      end else begin
        partial_code_next = CODE_BITS'(1);
        in_suffix_next    = 1'b1;
        suffix_left_next  = zero_run;
      end
    end else begin
      partial_code_next = code_shift;
      suffix_left_next  = suffix_dec;
      if (suffix_dec == '0) begin
        res               = 1'b1;
        res_code          = code_shift;
        partial_code_next = '0;
        zero_run_next     = '0;
        in_suffix_next    = 1'b0;
      end
    end
  end

  // unmapped value, taken modulo the output width
  assign code_w = WIDE'(res_code);
  assign half_w = code_w >> 1;
  assign sval_w = code_w[0] ? half_w : (~half_w + 1'b1);

  assign o_free = !out_valid || !out_stall;
  assign mv     = pend_valid && o_free && (pend_done || (have_bit && res));
  assign go     = have_bit && (!res || !pend_valid || mv);
  assign load   = q_valid && (!have_bit || (go && last_bit));
  assign q_pop  = load;

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= q_req.data;
    end else if (go) begin
      shreg <= {shreg[BYTE_BITS-2:0], 1'b0};
    end
    if (go && res) begin
      pend.code     <= code_w[OUT_BITS-1:0];
      pend.sval     <= sval_w[OUT_BITS-1:0];
      pend.too_long <= res_err;
      pend.last     <= 1'b0;
    end
    if (mv) begin
      out_res <= '{code: pend.code, sval: pend.sval, too_long: pend.too_long,
                   last: pend_done};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left    <= '0;
      partial_code <= '0;
      zero_run     <= '0;
      suffix_left  <= '0;
      in_suffix    <= 1'b0;
      pend_valid   <= 1'b0;
      pend_done    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (load) begin
        bits_left <= BIT_CNT_W'(BYTE_BITS);
      end else if (go) begin
        bits_left <= bits_left - 1'b1;
      end

      // restart clears after the last bit of the previous byte
      if (load && q_req.restart) begin
        partial_code <= '0;
        zero_run     <= '0;
        suffix_left  <= '0;
        in_suffix    <= 1'b0;
      end else if (go) begin
        partial_code <= partial_code_next;
        zero_run     <= zero_run_next;
        suffix_left  <= suffix_left_next;
        in_suffix    <= in_suffix_next;
      end

      // pending slot: a result waits until the next one or the byte end
      if (go && res) begin
        pend_valid <= 1'b1;
        pend_done  <= last_bit;
      end else begin
        if (mv) begin
          pend_valid <= 1'b0;
        end
        if (go && last_bit) begin
          pend_done <= 1'b1;
        end
      end

      if (mv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/elias_gamma_stream_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elias_gamma_stream_decoder
// decodes elias gamma code words from a byte stream, msb first
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  in       | request   | in_valid / in_stall  | data_byte, restart
//  out      | result    | out_valid / out_stall| code_value, signed_value,
//           |           |                      | too_long, last_of_byte
//
//  the bit walker takes each byte one bit per cycle unless a full pending
//  slot holds it; a byte request moves through a two-entry queue, so the
//  next byte loads as the last bit of the previous one is walked. a result
//  leaves at most one per cycle, after it waits in a pending slot until
//  the end of the byte or the next result fixes last_of_byte.
//  rst is synchronous and active high; it empties the queue and clears the
//  code state. out_stall holds the output register and, once the pending
//  slot is full, the walker; in_stall rises only while the queue is full.
// ----------------------------------------------------------------------------
module elias_gamma_stream_decoder import egsd_pkg::*; #(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // byte requests
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [BYTE_BITS-1:0]       data_byte,
  input  logic                       restart,
  // decoded results
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [OUT_BITS-1:0]        code_value,
  output logic signed [OUT_BITS-1:0] signed_value,
  output logic                       too_long,
  output logic                       last_of_byte
);

  // queue to walker
  logic      q_valid;
  egsd_req_t q_req;
  logic      q_pop;

  egsd_res_t out_res;

  // front: takes byte requests into the queue
  egsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .restart   (restart),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop)
  );

  // back: bit walker, pending slot and output register
  egsd_back #(
    .CODE_BITS (CODE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign code_value   = out_res.code;
  assign signed_value = out_res.sval;
  assign too_long     = out_res.too_long;
  assign last_of_byte = out_res.last;

endmodule
